// File: rtl/windowed_overlap_framer_macros.svh
// Assertion macros shared by the framer RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef WINDOWED_OVERLAP_FRAMER_MACROS_SVH
`define WINDOWED_OVERLAP_FRAMER_MACROS_SVH
// Check a property on every clock edge outside reset.
`define WOF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition is followed by a consequence in the next cycle.
`define WOF_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);
`endif

// File: rtl/wof_pkg.sv
// Types and constants of the windowed overlap framer.
// No dependencies; every other RTL file imports it.
package wof_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAME_LEN_W  = 10;
    localparam int STRIDE_W     = 12;
    localparam int KIND_W       = 2;
    localparam int STEP_W       = 25;
    localparam int PHASE_W      = 24;
    localparam int FRAMENUM_W   = 32;
    localparam int POS_W        = 9;
    localparam int STATUS_W     = 3;
    localparam int ACTION_W     = 2;
    localparam int RCV_W        = 32;
    localparam int PROD_W       = FRAMENUM_W + STRIDE_W;
    localparam int START_W      = PROD_W + 1;
    localparam int COEF_W       = 17;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [COEF_W-1:0] ONE_Q15 = 17'd32768;

    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_END  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PULL = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_PUSHED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_GIVEN   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NONE    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_END     = 3'd4;

    localparam logic [KIND_W-1:0] WIN_HAMMING = 2'd1;
    localparam logic [KIND_W-1:0] WIN_HANN    = 2'd2;

    localparam logic [1:0] REG_FRAME_LEN = 2'd0;
    localparam logic [1:0] REG_STRIDE    = 2'd1;
    localparam logic [1:0] REG_KIND      = 2'd2;
    localparam logic [1:0] REG_STEP      = 2'd3;

    typedef enum logic [1:0] {OP_PUSH, OP_END, OP_PULL, OP_BAD} op_t;
    typedef enum logic {ST_EVAL, ST_FIN} back_state_t;

    typedef struct packed {
        logic [ACTION_W-1:0]           action;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]           status;
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [FRAMENUM_W-1:0]         frame_number;
        logic [POS_W-1:0]              frame_position;
        logic                          last_in_frame;
        logic                          last_of_signal;
    } rsp_t;

    typedef struct packed {
        op_t                           op;
        logic signed [SAMPLE_BITS-1:0] sample;
    } q_entry_t;

    typedef struct packed {
        logic [FRAME_LEN_W-1:0] frame_len;
        logic [STRIDE_W-1:0]    stride_len;
        logic [KIND_W-1:0]      window_kind;
        logic [STEP_W-1:0]      window_phase_step;
    } cfg_t;

endpackage

// File: rtl/wof_front.sv
// Front end: accepts request transfers, decodes the action, queues them.
// Depends on wof_pkg.
module wof_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  wof_pkg::req_t     req,
    input  logic              pop,
    output logic              q_valid,
    output wof_pkg::q_entry_t q_head
);
    import wof_pkg::*;

    q_entry_t           entry_mem [QUEUE_DEPTH];
    q_entry_t           entry_in;
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;

    // decode the action code
    always_comb
    begin
        entry_in.sample = req.sample_in;
        case (req.action)
            ACT_PUSH: entry_in.op = OP_PUSH;
            ACT_END:  entry_in.op = OP_END;
            ACT_PULL: entry_in.op = OP_PULL;
            default:  entry_in.op = OP_BAD;
        endcase
    end

    assign req_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign q_valid   = (count_reg != '0);
    assign q_head    = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

// File: rtl/wof_window.sv
// Window coefficient unit: cosine table lookup and Hamming/Hann shaping.
// Depends on wof_pkg; result registered on enable.
module wof_window #(
    parameter int COS_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic [wof_pkg::PHASE_W-1:0]         phase,
    input  logic [wof_pkg::KIND_W-1:0]          kind,
    input  logic                                frame_one,
    output logic [wof_pkg::COEF_W-1:0]          w
);
    import wof_pkg::*;

    localparam int CIDX_W = $clog2(COS_DEPTH);
    localparam int SCL_W  = PHASE_W + CIDX_W + 2;
    localparam int IFW    = CIDX_W + 2;

    typedef logic signed [COEF_W-1:0] cos_arr_t [COS_DEPTH];

    // cos(2*pi*m/(4*depth)) in Q1.15 by a Taylor series in Q30
    function automatic logic [15:0] quarter_cos(longint unsigned m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (64'd6746518852 * m) / (4 * COS_DEPTH);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        sum = (sum + 16384) >>> 15;
        if (sum > 32768)
        begin
            sum = 32768;
        end
        return 16'(sum);
    endfunction

    function automatic cos_arr_t build_table();
        cos_arr_t        tab;
        longint unsigned quarter;
        longint unsigned q;
        longint unsigned r;
        for (int i = 0; i < COS_DEPTH; i++)
        begin
            quarter = 64'(4 * i);
            q = quarter / COS_DEPTH;
            r = quarter % COS_DEPTH;
            if (q == 0)
                tab[i] = $signed({1'b0, quarter_cos(r)});
            else if (q == 1)
                tab[i] = -$signed({1'b0, quarter_cos(64'(COS_DEPTH) - r)});
            else if (q == 2)
                tab[i] = -$signed({1'b0, quarter_cos(r)});
            else
                tab[i] = $signed({1'b0, quarter_cos(64'(COS_DEPTH) - r)});
        end
        return tab;
    endfunction

    localparam cos_arr_t COS_TAB = build_table();

    logic [SCL_W-1:0]         scaled;
    logic [IFW-1:0]           idx_full;
    logic [CIDX_W-1:0]        tab_idx;
    logic signed [COEF_W-1:0] c;
    logic signed [31:0]       ham;
    logic signed [COEF_W+1:0] hann;
    logic [COEF_W-1:0]        w_next;
    logic [COEF_W-1:0]        w_reg;

    always_comb
    begin
        scaled   = SCL_W'(phase) * SCL_W'(COS_DEPTH) + (SCL_W'(1) << (PHASE_W - 1));
        idx_full = scaled[SCL_W-1:PHASE_W];
        tab_idx  = (idx_full == IFW'(COS_DEPTH)) ? '0 : idx_full[CIDX_W-1:0];
        c        = COS_TAB[tab_idx];
        ham      = (32'sd579829760 + 32'sd16384 - 32'sd15073 * 32'(c)) >>> 15;
        hann     = (19'sd32769 - 19'(c)) >>> 1;
        if (frame_one)
            w_next = ONE_Q15;
        else if (kind == WIN_HAMMING)
            w_next = (ham > 32'sd32768) ? ONE_Q15 : COEF_W'(ham);
        else if (kind == WIN_HANN)
            w_next = (hann > 19'sd32768) ? ONE_Q15 : COEF_W'(hann);
        else
            w_next = ONE_Q15;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg <= w_next;
        end
    end

    assign w = w_reg;

endmodule

// File: rtl/wof_back.sv
// Back end: frame bookkeeping, sample ring and windowed output register.
// Depends on wof_pkg, wof_window and the assertion macro header.
`include "windowed_overlap_framer_macros.svh"
module wof_back #(
    parameter int RING_DEPTH = 512,
    parameter int COS_DEPTH  = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wof_pkg::cfg_t     cfg,
    input  logic              cfg_wr,
    input  logic              q_valid,
    input  wof_pkg::q_entry_t q_head,
    output logic              pop,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output wof_pkg::rsp_t     rsp
);
    import wof_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = AW + 1;

    back_state_t              st_reg, st_next;
    logic [RCV_W-1:0]         rcv_reg, rcv_next;
    logic [FRAMENUM_W-1:0]    cf_reg, cf_next;
    logic [AW-1:0]            p_reg, p_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic                     end_reg, end_next;
    logic [PROD_W-1:0]        start_reg;
    logic                     cfg_q_reg;

    logic [STATUS_W-1:0]      stat_reg, stat_next;
    logic [FRAMENUM_W-1:0]    cfn_reg, cfn_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic                     lif_reg, lif_next;
    logic                     los_reg, los_next;
    logic                     zero_reg, zero_next;

    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_reg, rsp_next;

    logic signed [SAMPLE_BITS-1:0] ring_mem [2**AW];
    logic signed [SAMPLE_BITS-1:0] ring_q;
    logic                     ring_we, ring_re;

    logic [FW-1:0]            f_eff;
    logic [STRIDE_W-1:0]      s_eff;
    logic [START_W-1:0]       start_w, p_w, s_w, f_w, rcv_w;
    logic [START_W-1:0]       oldest, idx, sf;
    logic                     refuse_push, last_pos, ready, last_sig;
    logic                     go, out_free, win_en;
    logic [COEF_W-1:0]        w;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic signed [SAMPLE_BITS+COEF_W:0] prod, rnd;

    // effective frame length and stride
    always_comb
    begin
        if (cfg.frame_len == '0)
            f_eff = FW'(1);
        else if (32'(cfg.frame_len) > RING_DEPTH)
            f_eff = FW'(RING_DEPTH);
        else
            f_eff = FW'(cfg.frame_len);
        s_eff = (cfg.stride_len == '0) ? STRIDE_W'(1) : cfg.stride_len;
    end

    // frame bookkeeping compares
    always_comb
    begin
        start_w     = START_W'(start_reg);
        p_w         = START_W'(p_reg);
        s_w         = START_W'(s_eff);
        f_w         = START_W'(f_eff);
        rcv_w       = START_W'(rcv_reg);
        oldest      = start_w + ((p_w < s_w) ? p_w : s_w);
        idx         = start_w + p_w;
        sf          = start_w + f_w;
        refuse_push = end_reg || (rcv_reg == '1) ||
                      ((rcv_w >= oldest) && ((rcv_w - oldest) >= START_W'(RING_DEPTH)));
        last_pos    = (p_w + START_W'(1)) >= f_w;
        ready       = end_reg || ((rcv_w > idx) && (!last_pos || (rcv_w > sf)));
        last_sig    = end_reg && last_pos && (sf >= rcv_w);
    end

    assign go       = (st_reg == ST_EVAL) && q_valid && !cfg_q_reg;
    assign pop      = go;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign win_en   = go && (q_head.op == OP_PULL);

    wof_window #(
        .COS_DEPTH (COS_DEPTH)
    ) u_window (
        .clk       (clk),
        .en        (win_en),
        .phase     (phase_reg),
        .kind      (cfg.window_kind),
        .frame_one (f_w <= START_W'(1)),
        .w         (w)
    );

    // round the windowed product; saturation is applied when the response is built
    always_comb
    begin
        smp  = zero_reg ? '0 : ring_q;
        prod = smp * $signed({1'b0, w});
        rnd  = (prod + 34'sd16384) >>> 15;
    end

    always_comb
    begin
        st_next   = st_reg;
        rcv_next  = rcv_reg;
        cf_next   = cf_reg;
        p_next    = p_reg;
        phase_next = phase_reg;
        end_next  = end_reg;
        stat_next = stat_reg;
        cfn_next  = cfn_reg;
        pos_next  = pos_reg;
        lif_next  = lif_reg;
        los_next  = los_reg;
        zero_next = zero_reg;
        ring_we   = 1'b0;
        ring_re   = 1'b0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next  = rsp_reg;

        case (st_reg)
            ST_EVAL:
            begin
                if (go)
                begin
                    st_next   = ST_FIN;
                    cfn_next  = '0;
                    pos_next  = '0;
                    lif_next  = 1'b0;
                    los_next  = 1'b0;
                    zero_next = 1'b1;
                    case (q_head.op)
                        OP_PUSH:
                        begin
                            if (refuse_push)
                                stat_next = STAT_REFUSED;
                            else
                            begin
                                stat_next = STAT_PUSHED;
                                ring_we   = 1'b1;
                                rcv_next  = rcv_reg + 1'b1;
                            end
                        end
                        OP_END:
                        begin
                            if (end_reg)
                                stat_next = STAT_REFUSED;
                            else
                            begin
                                stat_next = STAT_END;
                                end_next  = (rcv_reg != '0);
                            end
                        end
                        OP_PULL:
                        begin
                            if (!ready)
                                stat_next = STAT_NONE;
                            else
                            begin
                                stat_next = STAT_GIVEN;
                                ring_re   = 1'b1;
                                zero_next = !(idx < rcv_w);
                                cfn_next  = cf_reg;
                                pos_next  = POS_W'(p_reg);
                                lif_next  = last_pos;
                                los_next  = last_sig;
                                if (last_sig)
                                begin
                                    rcv_next   = '0;
                                    cf_next    = '0;
                                    p_next     = '0;
                                    phase_next = '0;
                                    end_next   = 1'b0;
                                end
                                else if (last_pos)
                                begin
                                    cf_next    = cf_reg + 1'b1;
                                    p_next     = '0;
                                    phase_next = '0;
                                end
                                else
                                begin
                                    p_next     = p_reg + 1'b1;
                                    phase_next = phase_reg + cfg.window_phase_step[PHASE_W-1:0];
                                end
                            end
                        end
                        default:
                        begin
                            stat_next = STAT_REFUSED;
                        end
                    endcase
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    st_next                 = ST_EVAL;
                    rsp_valid_next          = 1'b1;
                    rsp_next.status         = stat_reg;
                    rsp_next.frame_number   = cfn_reg;
                    rsp_next.frame_position = pos_reg;
                    rsp_next.last_in_frame  = lif_reg;
                    rsp_next.last_of_signal = los_reg;
                    if (stat_reg != STAT_GIVEN)
                        rsp_next.sample_out = '0;
                    else if (rnd > 34'sd32767)
                        rsp_next.sample_out = 16'sh7fff;
                    else if (rnd < -34'sd32768)
                        rsp_next.sample_out = 16'sh8000;
                    else
                        rsp_next.sample_out = SAMPLE_BITS'(rnd);
                end
            end
            default:
            begin
                st_next = ST_EVAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_EVAL;
            rcv_reg       <= '0;
            cf_reg        <= '0;
            p_reg         <= '0;
            phase_reg     <= '0;
            end_reg       <= 1'b0;
            start_reg     <= '0;
            cfg_q_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            rcv_reg       <= rcv_next;
            cf_reg        <= cf_next;
            p_reg         <= p_next;
            phase_reg     <= phase_next;
            end_reg       <= end_next;
            start_reg     <= PROD_W'(cf_reg) * PROD_W'(s_eff);
            cfg_q_reg     <= cfg_wr;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
        cfn_reg  <= cfn_next;
        pos_reg  <= pos_next;
        lif_reg  <= lif_next;
        los_reg  <= los_next;
        zero_reg <= zero_next;
        rsp_reg  <= rsp_next;
    end

    // sample ring: one write (push) or one registered read (pull) per cycle, only when an item is taken
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[rcv_reg[AW-1:0]] <= q_head.sample;
        end
        if (ring_re)
        begin
            ring_q <= ring_mem[idx[AW-1:0]];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `WOF_ASSERT(a_pop_after_cfg, pop |-> !cfg_q_reg, "item taken while start still settling")
    `WOF_ASSERT(a_no_push_after_end, ring_we |-> !end_reg, "ring written after end of signal")
    `WOF_ASSERT_NEXT(a_fin_delivers, st_reg == ST_FIN && out_free, rsp_valid_reg && st_reg == ST_EVAL, "finished item not delivered")
    `WOF_ASSERT(a_idle_fields, rsp_valid_reg && rsp_reg.status != STAT_GIVEN |-> rsp_reg.frame_number == '0 && rsp_reg.sample_out == '0, "non-output transfer carries data")

endmodule

// File: rtl/windowed_overlap_framer.sv
// Windowed overlap framer top level: APB registers, front queue, back engine.
// A request is queued by the front end, taken in the back engine's evaluate state and
// delivered from its finish state via the registered rsp_valid; a new item is taken only
// after that delivery (ring read and window multiply feed the finish state, frame start
// product between items). Reset (rst_n, async low): registers to 400/160/Hamming/42052,
// counters and queue empty; sample ring not cleared, reads past received samples are zero.
module windowed_overlap_framer #(
    parameter int RING_DEPTH = 512,
    parameter int COS_DEPTH  = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wof_pkg::APB_AW-1:0]    paddr,
    input  logic [wof_pkg::APB_DW-1:0]    pwdata,
    output logic [wof_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  wof_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output wof_pkg::rsp_t                 rsp
);
    import wof_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      cfg_wr;
    logic      pop;
    logic      q_valid;
    q_entry_t  q_head;

    assign pready = 1'b1;
    // register write completes on the access cycle
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FRAME_LEN: cfg_next.frame_len         = pwdata[FRAME_LEN_W-1:0];
                REG_STRIDE:    cfg_next.stride_len        = pwdata[STRIDE_W-1:0];
                REG_KIND:      cfg_next.window_kind       = pwdata[KIND_W-1:0];
                REG_STEP:      cfg_next.window_phase_step = pwdata[STEP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // read back the addressed register, zero extended
    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_LEN: prdata = APB_DW'(cfg_reg.frame_len);
            REG_STRIDE:    prdata = APB_DW'(cfg_reg.stride_len);
            REG_KIND:      prdata = APB_DW'(cfg_reg.window_kind);
            REG_STEP:      prdata = APB_DW'(cfg_reg.window_phase_step);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_len         <= 10'd400;
            cfg_reg.stride_len        <= 12'd160;
            cfg_reg.window_kind       <= WIN_HAMMING;
            cfg_reg.window_phase_step <= 25'd42052;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and decode request transfers into a short queue
    wof_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_head    (q_head)
    );

    // back: advance frame state, read the ring, window and deliver
    wof_back #(
        .RING_DEPTH (RING_DEPTH),
        .COS_DEPTH  (COS_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_wr    (cfg_wr),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
